[hdl/gcd_pkg.sv]
// Shared widths, constants and the CORDIC arctangent table for the distance core.
`default_nettype none

package gcd_pkg;

  // Three angle lanes: both latitudes and the longitude difference
  localparam int LANES      = 3;
  localparam int LANE_LAT_A = 0;
  localparam int LANE_LAT_B = 1;
  localparam int LANE_DLON  = 2;

  // Datapath widths
  localparam int MAG_W  = 26;            // magnitude of a degree value, incl. lon difference
  localparam int BAM_W  = 32;            // binary angle, 2^32 per turn
  localparam int CS_W   = 32;            // sine / cosine in Q30
  localparam int XY_W   = 34;            // CORDIC vector components
  localparam int Z_W    = 34;            // CORDIC angle accumulator
  localparam int SQ_W   = 31;            // square root result
  localparam int RAD_W  = 61;            // radicand 2^60 - c^2
  localparam int PROD_W = 2 * CS_W;
  localparam int Q_FRAC = 30;

  // Degrees per turn, used by the constant divider
  localparam logic [9:0] DEG_PER_TURN  = 10'd360;
  localparam logic [8:0] HALF_TURN_DEG = 9'd180;

  // Fixed-point constants
  localparam logic signed [XY_W-1:0]   INV_GAIN_Q30 = 34'sh26DD3B6A;
  localparam logic signed [CS_W:0]     ONE_Q30_W    = 33'sd1073741824;
  localparam logic signed [CS_W-1:0]   ONE_Q30      = 32'sd1073741824;
  localparam logic signed [Z_W-1:0]    Z_QUARTER    = 34'sd1073741824;
  localparam logic signed [Z_W-1:0]    Z_HALF       = 34'sd2147483648;
  localparam logic signed [PROD_W-1:0] RND_Q30      = 64'sd536870912;
  localparam logic [RAD_W-1:0]         ONE_Q60      = 61'h1000000000000000;

  // km per turn times 256 in Q9, split 17 + 16 bits for the final scaling
  localparam logic [16:0] KM_TURN_HI = 17'd80056;
  localparam logic [15:0] KM_TURN_LO = 16'd32467;
  localparam int          KM_SHIFT   = 41;

  // atan(2^-i) in 2^-32 turn
  function automatic logic [BAM_W-1:0] atan_entry(input logic [4:0] idx);
    logic [BAM_W-1:0] val;
    unique case (idx)
      5'd0:  val = 32'h20000000;
      5'd1:  val = 32'h12E4051E;
      5'd2:  val = 32'h09FB385B;
      5'd3:  val = 32'h051111D4;
      5'd4:  val = 32'h028B0D43;
      5'd5:  val = 32'h0145D7E1;
      5'd6:  val = 32'h00A2F61E;
      5'd7:  val = 32'h00517C55;
      5'd8:  val = 32'h0028BE53;
      5'd9:  val = 32'h00145F2F;
      5'd10: val = 32'h000A2F98;
      5'd11: val = 32'h000517CC;
      5'd12: val = 32'h00028BE6;
      5'd13: val = 32'h000145F3;
      5'd14: val = 32'h0000A2FA;
      5'd15: val = 32'h0000517D;
      5'd16: val = 32'h000028BE;
      5'd17: val = 32'h0000145F;
      5'd18: val = 32'h00000A30;
      5'd19: val = 32'h00000518;
      5'd20: val = 32'h0000028C;
      5'd21: val = 32'h00000146;
      5'd22: val = 32'h000000A3;
      5'd23: val = 32'h00000051;
      5'd24: val = 32'h00000029;
      5'd25: val = 32'h00000014;
      5'd26: val = 32'h0000000A;
      5'd27: val = 32'h00000005;
      5'd28: val = 32'h00000003;
      5'd29: val = 32'h00000001;
      5'd30: val = 32'h00000001;
      5'd31: val = 32'h00000000;
    endcase
    return val;
  endfunction

endpackage

`default_nettype wire

[hdl/gcd_deg2bam.sv]
// Degrees to binary angle: pipelined long division by 360, eight bits a stage.
`default_nettype none

module gcd_deg2bam #(
  parameter int ANGLE_FRAC_BITS = 16
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       en_i,
  input  logic                       valid_i,
  input  logic [gcd_pkg::LANES-1:0]  neg_i,
  input  logic [gcd_pkg::MAG_W-1:0]  mag_i [gcd_pkg::LANES],
  output logic                       valid_o,
  output logic [gcd_pkg::BAM_W-1:0]  bam_o [gcd_pkg::LANES]
);
  import gcd_pkg::*;

  localparam int SHIFT = BAM_W - ANGLE_FRAC_BITS;
  localparam int NUM_W = MAG_W + SHIFT;
  localparam int STEPS = 8;
  localparam int NSTG  = (NUM_W + STEPS - 1) / STEPS;
  localparam int PAD_W = NSTG * STEPS;
  localparam int REM_W = 9;

  logic [REM_W-1:0] rem_q [NSTG+1][LANES];
  logic [PAD_W-1:0] num_q [NSTG+1][LANES];
  logic [BAM_W-1:0] quo_q [NSTG+1][LANES];
  logic [REM_W-1:0] rem_d [NSTG][LANES];
  logic [PAD_W-1:0] num_d [NSTG][LANES];
  logic [BAM_W-1:0] quo_d [NSTG][LANES];
  logic [LANES-1:0] neg_q [NSTG+1];
  logic [NSTG:0]    vld_q;
  logic [BAM_W-1:0] bam_d [LANES];
  logic [BAM_W-1:0] bam_q [LANES];
  logic             out_vld_q;

  // Restoring division steps, one quotient bit each
  always_comb begin
    logic [REM_W:0]   r;
    logic [PAD_W-1:0] n;
    logic [BAM_W-1:0] q;
    for (int k = 0; k < NSTG; k++) begin
      for (int l = 0; l < LANES; l++) begin
        r = {1'b0, rem_q[k][l]};
        n = num_q[k][l];
        q = quo_q[k][l];
        for (int j = 0; j < STEPS; j++) begin
          r = {r[REM_W-1:0], n[PAD_W-1]};
          n = n << 1;
          if (r >= DEG_PER_TURN) begin
            r = r - DEG_PER_TURN;
            q = {q[BAM_W-2:0], 1'b1};
          end else begin
            q = {q[BAM_W-2:0], 1'b0};
          end
        end
        rem_d[k][l] = r[REM_W-1:0];
        num_d[k][l] = n;
        quo_d[k][l] = q;
      end
    end
  end

  // Round half up on the magnitude, then apply the sign modulo one turn
  always_comb begin
    logic [BAM_W-1:0] q;
    for (int l = 0; l < LANES; l++) begin
      q = quo_q[NSTG][l] + BAM_W'(rem_q[NSTG][l] >= HALF_TURN_DEG);
      bam_d[l] = neg_q[NSTG][l] ? (~q + 1'b1) : q;
    end
  end

  // Valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      out_vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q     <= {vld_q[NSTG-1:0], valid_i};
      out_vld_q <= vld_q[NSTG];
    end
  end

  // Division pipeline payload
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      neg_q[0] <= neg_i;
      for (int l = 0; l < LANES; l++) begin
        rem_q[0][l] <= '0;
        num_q[0][l] <= {{(PAD_W-MAG_W){1'b0}}, mag_i[l]} << SHIFT;
        quo_q[0][l] <= '0;
        bam_q[l]    <= bam_d[l];
      end
      for (int k = 0; k < NSTG; k++) begin
        neg_q[k+1] <= neg_q[k];
        for (int l = 0; l < LANES; l++) begin
          rem_q[k+1][l] <= rem_d[k][l];
          num_q[k+1][l] <= num_d[k][l];
          quo_q[k+1][l] <= quo_d[k][l];
        end
      end
    end
  end

  assign valid_o = out_vld_q;
  assign bam_o   = bam_q;

endmodule

`default_nettype wire

[hdl/gcd_cordic_rot.sv]
// Rotation CORDIC, one iteration a stage: sine and cosine of three binary angles.
`default_nettype none

module gcd_cordic_rot #(
  parameter int CORDIC_STAGES = 24
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             en_i,
  input  logic                             valid_i,
  input  logic [gcd_pkg::BAM_W-1:0]        bam_i [gcd_pkg::LANES],
  output logic                             valid_o,
  output logic signed [gcd_pkg::CS_W-1:0]  cos_o [gcd_pkg::LANES],
  output logic signed [gcd_pkg::CS_W-1:0]  sin_o [gcd_pkg::LANES]
);
  import gcd_pkg::*;

  localparam int NST = CORDIC_STAGES;

  logic signed [XY_W-1:0] x_q [NST+1][LANES];
  logic signed [XY_W-1:0] y_q [NST+1][LANES];
  logic signed [Z_W-1:0]  z_q [NST+1][LANES];
  logic signed [XY_W-1:0] x_d [NST][LANES];
  logic signed [XY_W-1:0] y_d [NST][LANES];
  logic signed [Z_W-1:0]  z_d [NST][LANES];
  logic [LANES-1:0]       flip_q [NST+1];
  logic [LANES-1:0]       flip_d;
  logic signed [Z_W-1:0]  z0_d [LANES];
  logic [NST:0]           vld_q;
  logic signed [CS_W-1:0] cos_q [LANES];
  logic signed [CS_W-1:0] sin_q [LANES];
  logic                   out_vld_q;

  // Quadrants II and III turn by half a turn first
  always_comb begin
    logic [BAM_W-1:0] th;
    for (int l = 0; l < LANES; l++) begin
      flip_d[l] = (bam_i[l][BAM_W-1:BAM_W-2] == 2'd1) || (bam_i[l][BAM_W-1:BAM_W-2] == 2'd2);
      th        = flip_d[l] ? (bam_i[l] - 32'h80000000) : bam_i[l];
      z0_d[l]   = {{(Z_W-BAM_W){th[BAM_W-1]}}, th};
    end
  end

  // Micro-rotations
  always_comb begin
    logic signed [XY_W-1:0] xs;
    logic signed [XY_W-1:0] ys;
    logic signed [Z_W-1:0]  at;
    for (int k = 0; k < NST; k++) begin
      for (int l = 0; l < LANES; l++) begin
        xs = x_q[k][l] >>> k;
        ys = y_q[k][l] >>> k;
        at = {{(Z_W-BAM_W){1'b0}}, atan_entry(5'(k))};
        if (!z_q[k][l][Z_W-1]) begin
          x_d[k][l] = x_q[k][l] - ys;
          y_d[k][l] = y_q[k][l] + xs;
          z_d[k][l] = z_q[k][l] - at;
        end else begin
          x_d[k][l] = x_q[k][l] + ys;
          y_d[k][l] = y_q[k][l] - xs;
          z_d[k][l] = z_q[k][l] + at;
        end
      end
    end
  end

  // Valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      out_vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q     <= {vld_q[NST-1:0], valid_i};
      out_vld_q <= vld_q[NST];
    end
  end

  // Payload, undo the half-turn at the end
  always_ff @(posedge clk_i) begin
    logic signed [XY_W-1:0] cx;
    logic signed [XY_W-1:0] sy;
    if (en_i) begin
      flip_q[0] <= flip_d;
      for (int l = 0; l < LANES; l++) begin
        x_q[0][l] <= INV_GAIN_Q30;
        y_q[0][l] <= '0;
        z_q[0][l] <= z0_d[l];
        cx = flip_q[NST][l] ? -x_q[NST][l] : x_q[NST][l];
        sy = flip_q[NST][l] ? -y_q[NST][l] : y_q[NST][l];
        cos_q[l] <= cx[CS_W-1:0];
        sin_q[l] <= sy[CS_W-1:0];
      end
      for (int k = 0; k < NST; k++) begin
        flip_q[k+1] <= flip_q[k];
        for (int l = 0; l < LANES; l++) begin
          x_q[k+1][l] <= x_d[k][l];
          y_q[k+1][l] <= y_d[k][l];
          z_q[k+1][l] <= z_d[k][l];
        end
      end
    end
  end

  assign valid_o = out_vld_q;
  assign cos_o   = cos_q;
  assign sin_o   = sin_q;

endmodule

`default_nettype wire

[hdl/gcd_isqrt.sv]
// Pipelined integer floor square root, one result bit a stage.
`default_nettype none

module gcd_isqrt #(
  parameter int SIDE_W = 33
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      en_i,
  input  logic                      valid_i,
  input  logic [gcd_pkg::RAD_W-1:0] rad_i,
  input  logic [SIDE_W-1:0]         side_i,
  output logic                      valid_o,
  output logic [gcd_pkg::SQ_W-1:0]  root_o,
  output logic [SIDE_W-1:0]         side_o
);
  import gcd_pkg::*;

  localparam int NRT   = SQ_W;
  localparam int RES_W = RAD_W + 1;

  logic [RAD_W-1:0]  v_q   [NRT+1];
  logic [RES_W-1:0]  res_q [NRT+1];
  logic [SIDE_W-1:0] side_q [NRT+1];
  logic [RAD_W-1:0]  v_d   [NRT];
  logic [RES_W-1:0]  res_d [NRT];
  logic [NRT:0]      vld_q;

  // One trial subtraction a stage
  always_comb begin
    logic [RES_W-1:0] b;
    logic [RES_W-1:0] t;
    for (int k = 0; k < NRT; k++) begin
      b = RES_W'(1) << (2 * (NRT - 1 - k));
      t = res_q[k] + b;
      if ({1'b0, v_q[k]} >= t) begin
        v_d[k]   = v_q[k] - t[RAD_W-1:0];
        res_d[k] = (res_q[k] >> 1) + b;
      end else begin
        v_d[k]   = v_q[k];
        res_d[k] = res_q[k] >> 1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[NRT-1:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      v_q[0]    <= rad_i;
      res_q[0]  <= '0;
      side_q[0] <= side_i;
      for (int k = 0; k < NRT; k++) begin
        v_q[k+1]    <= v_d[k];
        res_q[k+1]  <= res_d[k];
        side_q[k+1] <= side_q[k];
      end
    end
  end

  assign valid_o = vld_q[NRT];
  assign root_o  = res_q[NRT][SQ_W-1:0];
  assign side_o  = side_q[NRT];

endmodule

`default_nettype wire

[hdl/gcd_cordic_vec.sv]
// Vectoring CORDIC for acos(c) = atan2(s, c), one iteration a stage.
`default_nettype none

module gcd_cordic_vec #(
  parameter int CORDIC_STAGES = 24,
  parameter int SIDE_W        = 1
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            en_i,
  input  logic                            valid_i,
  input  logic signed [gcd_pkg::CS_W-1:0] c_i,
  input  logic [gcd_pkg::SQ_W-1:0]        s_i,
  input  logic [SIDE_W-1:0]               side_i,
  output logic                            valid_o,
  output logic [gcd_pkg::BAM_W-1:0]       angle_o,
  output logic [SIDE_W-1:0]               side_o
);
  import gcd_pkg::*;

  localparam int NST = CORDIC_STAGES;

  logic signed [XY_W-1:0] x_q [NST+1];
  logic signed [XY_W-1:0] y_q [NST+1];
  logic signed [Z_W-1:0]  z_q [NST+1];
  logic signed [XY_W-1:0] x_d [NST];
  logic signed [XY_W-1:0] y_d [NST];
  logic signed [Z_W-1:0]  z_d [NST];
  logic [SIDE_W-1:0]      side_q [NST+1];
  logic [NST:0]           vld_q;
  logic signed [XY_W-1:0] x0_d;
  logic signed [XY_W-1:0] y0_d;
  logic signed [Z_W-1:0]  z0_d;
  logic [BAM_W-1:0]       ang_d;
  logic [BAM_W-1:0]       ang_q;
  logic [SIDE_W-1:0]      out_side_q;
  logic                   out_vld_q;

  // Negative cosine: start a quarter turn on
  always_comb begin
    logic signed [XY_W-1:0] cx;
    logic signed [XY_W-1:0] sx;
    cx = {{(XY_W-CS_W){c_i[CS_W-1]}}, c_i};
    sx = {{(XY_W-SQ_W){1'b0}}, s_i};
    if (c_i[CS_W-1]) begin
      x0_d = sx;
      y0_d = -cx;
      z0_d = Z_QUARTER;
    end else begin
      x0_d = cx;
      y0_d = sx;
      z0_d = '0;
    end
  end

  // Drive y towards zero
  always_comb begin
    logic signed [XY_W-1:0] xs;
    logic signed [XY_W-1:0] ys;
    logic signed [Z_W-1:0]  at;
    for (int k = 0; k < NST; k++) begin
      xs = x_q[k] >>> k;
      ys = y_q[k] >>> k;
      at = {{(Z_W-BAM_W){1'b0}}, atan_entry(5'(k))};
      if (y_q[k] > 0) begin
        x_d[k] = x_q[k] + ys;
        y_d[k] = y_q[k] - xs;
        z_d[k] = z_q[k] + at;
      end else begin
        x_d[k] = x_q[k] - ys;
        y_d[k] = y_q[k] + xs;
        z_d[k] = z_q[k] - at;
      end
    end
  end

  // Saturate the angle into [0, half turn]
  always_comb begin
    if (z_q[NST][Z_W-1]) begin
      ang_d = '0;
    end else if (z_q[NST] > Z_HALF) begin
      ang_d = Z_HALF[BAM_W-1:0];
    end else begin
      ang_d = z_q[NST][BAM_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      out_vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q     <= {vld_q[NST-1:0], valid_i};
      out_vld_q <= vld_q[NST];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q[0]     <= x0_d;
      y_q[0]     <= y0_d;
      z_q[0]     <= z0_d;
      side_q[0]  <= side_i;
      ang_q      <= ang_d;
      out_side_q <= side_q[NST];
      for (int k = 0; k < NST; k++) begin
        x_q[k+1]    <= x_d[k];
        y_q[k+1]    <= y_d[k];
        z_q[k+1]    <= z_d[k];
        side_q[k+1] <= side_q[k];
      end
    end
  end

  assign valid_o = out_vld_q;
  assign angle_o = ang_q;
  assign side_o  = out_side_q;

endmodule

`default_nettype wire

[hdl/great_circle_distance_core.sv]
// Great-circle distance core: top level with products, clamp and km scaling.
//
// Usage:
//   Input request: in_valid_i / in_ready_o with lat_a_i, lon_a_i, lat_b_i, lon_b_i
//   in signed degrees with ANGLE_FRAC_BITS fraction bits. Output request:
//   out_valid_o / out_ready_i with distance_km_o (km * 256) and clamped_o,
//   set when the cosine sum left [-1, 1] and was saturated.
//   Throughput: one request per cycle unless the output stalls; every stage
//   is a fixed pipeline step. The divide-by-360 front end is D = ceil((58 -
//   ANGLE_FRAC_BITS) / 8) stages deep, the two CORDIC units run one
//   iteration per stage and the square root has 31 stages.
//   Stall: the whole pipeline holds while a result waits in the output
//   register and out_ready_i is low; in_ready_o then drops. Nothing is lost
//   or repeated, and a new request is taken in the cycle the result leaves.
//   Reset: rst_ni clears all valid bits; the pipeline comes up empty.
`default_nettype none

module great_circle_distance_core #(
  parameter int ANGLE_FRAC_BITS = 16,
  parameter int CORDIC_STAGES   = 24
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [23:0] lat_a_i,
  input  logic signed [24:0] lon_a_i,
  input  logic signed [23:0] lat_b_i,
  input  logic signed [24:0] lon_b_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [22:0]        distance_km_o,
  output logic               clamped_o
);
  import gcd_pkg::*;

  localparam int ISQ_SIDE_W = CS_W + 1;
  localparam int PA_W       = BAM_W + 17;
  localparam int PB_W       = BAM_W + 16;
  localparam int FS_W       = PA_W + 17;

  logic en;

  // Front end signals
  logic signed [MAG_W-1:0] ang_in [LANES];
  logic [MAG_W-1:0]        mag_in [LANES];
  logic [LANES-1:0]        neg_in;

  logic                    bam_vld;
  logic [BAM_W-1:0]        bam [LANES];
  logic                    cs_vld;
  logic signed [CS_W-1:0]  cos_v [LANES];
  logic signed [CS_W-1:0]  sin_v [LANES];

  // Product and clamp stages
  logic signed [PROD_W-1:0] pss_d, pcc_d, pcd_d;
  logic signed [CS_W-1:0]   t1_d, p_d, t2_d;
  logic signed [CS_W-1:0]   t1_q, p_q, cd_q, t1b_q, t2_q;
  logic                     m1_vld_q, m2_vld_q, m3_vld_q, sq_vld_q;
  logic signed [CS_W:0]     csum_d;
  logic signed [CS_W-1:0]   c_d, c_q, csq_q;
  logic                     clamp_d, clamp_q, clamp_sq_q;
  logic signed [PROD_W-1:0] sq_d;
  logic [RAD_W-1:0]         sq_q;
  logic [RAD_W-1:0]         rad;

  logic                     rt_vld;
  logic [SQ_W-1:0]          root;
  logic [ISQ_SIDE_W-1:0]    rt_side;

  logic                     ac_vld;
  logic [BAM_W-1:0]         ang;
  logic                     ac_clamp;

  logic [PA_W-1:0]          pa_q;
  logic [PB_W-1:0]          pb_q;
  logic                     f1_clamp_q, f1_vld_q;
  logic [FS_W-1:0]          fsum_d;
  logic [22:0]              dist_q;
  logic                     out_clamp_q, out_vld_q;

  // Pipeline advances unless a result is held in the output register
  assign en         = !out_vld_q || out_ready_i;
  assign in_ready_o = en;

  // Sign and magnitude of both latitudes and the longitude difference
  always_comb begin
    ang_in[LANE_LAT_A] = {{(MAG_W-24){lat_a_i[23]}}, lat_a_i};
    ang_in[LANE_LAT_B] = {{(MAG_W-24){lat_b_i[23]}}, lat_b_i};
    ang_in[LANE_DLON]  = {lon_a_i[24], lon_a_i} - {lon_b_i[24], lon_b_i};
    for (int l = 0; l < LANES; l++) begin
      neg_in[l] = ang_in[l][MAG_W-1];
      mag_in[l] = neg_in[l] ? -ang_in[l] : ang_in[l];
    end
  end

  gcd_deg2bam #(
    .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
  ) u_deg2bam (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_valid_i),
    .neg_i   (neg_in),
    .mag_i   (mag_in),
    .valid_o (bam_vld),
    .bam_o   (bam)
  );

  gcd_cordic_rot #(
    .CORDIC_STAGES (CORDIC_STAGES)
  ) u_rot (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (bam_vld),
    .bam_i   (bam),
    .valid_o (cs_vld),
    .cos_o   (cos_v),
    .sin_o   (sin_v)
  );

  // Q30 products, rounded
  always_comb begin
    pss_d = sin_v[LANE_LAT_A] * sin_v[LANE_LAT_B];
    pcc_d = cos_v[LANE_LAT_A] * cos_v[LANE_LAT_B];
    t1_d  = CS_W'((pss_d + RND_Q30) >>> Q_FRAC);
    p_d   = CS_W'((pcc_d + RND_Q30) >>> Q_FRAC);
    pcd_d = p_q * cd_q;
    t2_d  = CS_W'((pcd_d + RND_Q30) >>> Q_FRAC);
  end

  // Cosine sum, saturated to [-1, 1]
  always_comb begin
    csum_d  = {t1b_q[CS_W-1], t1b_q} + {t2_q[CS_W-1], t2_q};
    clamp_d = 1'b0;
    if (csum_d > ONE_Q30_W) begin
      c_d     = ONE_Q30;
      clamp_d = 1'b1;
    end else if (csum_d < -ONE_Q30_W) begin
      c_d     = -ONE_Q30;
      clamp_d = 1'b1;
    end else begin
      c_d = csum_d[CS_W-1:0];
    end
    sq_d = c_q * c_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m1_vld_q <= 1'b0;
      m2_vld_q <= 1'b0;
      m3_vld_q <= 1'b0;
      sq_vld_q <= 1'b0;
    end else if (en) begin
      m1_vld_q <= cs_vld;
      m2_vld_q <= m1_vld_q;
      m3_vld_q <= m2_vld_q;
      sq_vld_q <= m3_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      t1_q       <= t1_d;
      p_q        <= p_d;
      cd_q       <= cos_v[LANE_DLON];
      t1b_q      <= t1_q;
      t2_q       <= t2_d;
      c_q        <= c_d;
      clamp_q    <= clamp_d;
      sq_q       <= sq_d[RAD_W-1:0];
      csq_q      <= c_q;
      clamp_sq_q <= clamp_q;
    end
  end

  assign rad = ONE_Q60 - sq_q;

  gcd_isqrt #(
    .SIDE_W (ISQ_SIDE_W)
  ) u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (sq_vld_q),
    .rad_i   (rad),
    .side_i  ({clamp_sq_q, csq_q}),
    .valid_o (rt_vld),
    .root_o  (root),
    .side_o  (rt_side)
  );

  gcd_cordic_vec #(
    .CORDIC_STAGES (CORDIC_STAGES),
    .SIDE_W        (1)
  ) u_vec (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (rt_vld),
    .c_i     (rt_side[CS_W-1:0]),
    .s_i     (root),
    .side_i  (rt_side[CS_W]),
    .valid_o (ac_vld),
    .angle_o (ang),
    .side_o  (ac_clamp)
  );

  // Angle to km: two partial products, then sum and round
  assign fsum_d = {1'b0, pa_q, 16'b0} + {{(FS_W-PB_W){1'b0}}, pb_q} + (FS_W'(1) << (KM_SHIFT - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f1_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else if (en) begin
      f1_vld_q  <= ac_vld;
      out_vld_q <= f1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      pa_q        <= ang * KM_TURN_HI;
      pb_q        <= ang * KM_TURN_LO;
      f1_clamp_q  <= ac_clamp;
      dist_q      <= fsum_d[KM_SHIFT+22:KM_SHIFT];
      out_clamp_q <= f1_clamp_q;
    end
  end

  assign out_valid_o   = out_vld_q;
  assign distance_km_o = dist_q;
  assign clamped_o     = out_clamp_q;

  // A saturated cosine sum sits exactly on +1 or -1
  a_clamp_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m3_vld_q && clamp_q) |-> (c_q == ONE_Q30 || c_q == -ONE_Q30))
    else $error("clamped cosine sum not at +-1");

  // The radicand never wraps: c^2 stays at or below one
  a_radicand: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sq_vld_q |-> (sq_q <= ONE_Q60))
    else $error("square of cosine sum exceeds one");

  // Half a turn is the longest distance
  a_dist_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (distance_km_o <= 23'd5124096))
    else $error("distance beyond half a turn");

endmodule

`default_nettype wire
